/* rtl/wpms_pkg.sv */
// Shared types, constants and lamp-pattern helper for the wiper press-mode sequencer.
// No dependencies; imported by every module of the block.
package wpms_pkg;

  localparam int PRESS_W = 24;
  localparam int UNIT_W  = 16;
  localparam int TIMER_W = 20;
  localparam int SPEED_W = 2;
  localparam int PHASE_W = 2;
  localparam int LAMP_W  = 4;
  localparam int ADDR_W  = 3;
  localparam int DATA_W  = 32;

  localparam logic [PRESS_W-1:0] PRESS_MAX        = '1;
  localparam logic [PRESS_W-1:0] LONG_PRESS_RESET = PRESS_W'(50000);
  localparam logic [UNIT_W-1:0]  PHASE_UNIT_RESET = UNIT_W'(1000);
  localparam logic [SPEED_W-1:0] SPEED_TOP        = SPEED_W'(3);

  // Register indexes (byte address / 4)
  localparam logic REG_LONG_PRESS = 1'b0;
  localparam logic REG_PHASE_UNIT = 1'b1;

  localparam logic [LAMP_W-1:0] LAMP_OFF = 4'h0;
  localparam logic [LAMP_W-1:0] LAMP_RED = 4'h4;

  // Wiper state after the button has been judged for the current beat
  typedef struct packed {
    logic                wiper_on;
    logic [SPEED_W-1:0]  speed;
  } wiper_state_t;

  function automatic logic [LAMP_W-1:0] lamp_pattern(input logic [PHASE_W-1:0] ph);
    logic [LAMP_W-1:0] lp;
    case (ph)
      2'd0:    lp = 4'h5;
      2'd1:    lp = 4'h6;
      2'd2:    lp = 4'hC;
      default: lp = 4'h6;
    endcase
    return lp;
  endfunction

endpackage

/* rtl/wpms_press.sv */
// Press timer and judge: counts held ticks, toggles the wiper and steps the speed.
// Depends on wpms_pkg.
module wpms_press import wpms_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               advance,
  input  logic               button_level,
  input  logic [PRESS_W-1:0] long_press_ticks,
  output wiper_state_t       st_nxt
);

  logic [PRESS_W-1:0] press_length_r, press_length_nxt;
  wiper_state_t       st_r;

  always_comb begin
    press_length_nxt = press_length_r;
    st_nxt           = st_r;
    if (button_level) begin
      if (press_length_r != PRESS_MAX) press_length_nxt = press_length_r + 1'b1;
    end else if (press_length_r != '0) begin
      press_length_nxt = '0;
      if (press_length_r > long_press_ticks) begin
        st_nxt.wiper_on = !st_r.wiper_on;
        if (!st_r.wiper_on) st_nxt.speed = '0;
      end else if (press_length_r < long_press_ticks && st_r.wiper_on) begin
        st_nxt.speed = (st_r.speed == SPEED_TOP) ? SPEED_W'(1) : st_r.speed + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      press_length_r <= '0;
      st_r           <= '0;
    end else if (advance) begin
      press_length_r <= press_length_nxt;
      st_r           <= st_nxt;
    end
  end

endmodule

/* rtl/wpms_lamp.sv */
// Lamp phase sequencer: phase counter and phase timer scaled by speed squared.
// Depends on wpms_pkg.
module wpms_lamp import wpms_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               advance,
  input  wiper_state_t       st,
  input  logic [UNIT_W-1:0]  phase_unit_ticks,
  output logic [LAMP_W-1:0]  lamps
);

  logic [PHASE_W-1:0] phase_r, phase_nxt;
  logic [TIMER_W-1:0] timer_r, timer_nxt;
  logic [TIMER_W-1:0] unit_ext, len, len_fix, cur;

  // speed^2 * unit with shifts and adds: 1, 4 or 9 times the unit
  always_comb begin
    unit_ext = TIMER_W'(phase_unit_ticks);
    case (st.speed)
      2'd2:    len = unit_ext << 2;
      2'd3:    len = (unit_ext << 3) + unit_ext;
      default: len = unit_ext;
    endcase
    len_fix = (len == '0) ? TIMER_W'(1) : len;
    cur     = (timer_r == '0) ? len_fix : timer_r;
  end

  always_comb begin
    lamps     = LAMP_OFF;
    phase_nxt = '0;
    timer_nxt = '0;
    if (st.wiper_on) begin
      if (st.speed == '0) begin
        lamps = LAMP_RED;
      end else begin
        lamps     = lamp_pattern(phase_r);
        timer_nxt = cur - 1'b1;
        phase_nxt = (cur == TIMER_W'(1)) ? phase_r + 1'b1 : phase_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
      timer_r <= '0;
    end else if (advance) begin
      phase_r <= phase_nxt;
      timer_r <= timer_nxt;
    end
  end

endmodule

/* rtl/wiper_press_mode_sequencer_core.sv */
// Pipeline: input register, then result register, between input beat and result beat.
// Throughput: one beat per cycle while out_ready stays high; a stall holds both stages.
// Reset (rst_n, synchronous, active low): wiper off, speed 0, press timer, phase and
// phase timer cleared, both pipeline stages empty, registers at 50000 and 1000.
// The rate is set by the single state update per beat in the press and lamp units.
// Depends on wpms_pkg, wpms_press and wpms_lamp.
module wiper_press_mode_sequencer_core import wpms_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  // input channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_button_level,
  // result channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic [LAMP_W-1:0]  out_lamps,
  output logic               out_wiper_enabled,
  output logic [SPEED_W-1:0] out_speed_level,
  // configuration port
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [ADDR_W-1:0]  cfg_paddr,
  input  logic [DATA_W-1:0]  cfg_pwdata,
  output logic [DATA_W-1:0]  cfg_prdata,
  output logic               cfg_pready
);

  // Configuration registers
  logic [PRESS_W-1:0] long_press_r;
  logic [UNIT_W-1:0]  phase_unit_r;
  logic               cfg_index;
  logic               cfg_wr;

  // Input stage
  logic               in_valid_r;
  logic               in_button_r;
  logic               advance;

  // Result stage
  logic               out_valid_r;
  logic [LAMP_W-1:0]  out_lamps_r;
  logic               out_wiper_r;
  logic [SPEED_W-1:0] out_speed_r;

  wiper_state_t       st_nxt;
  logic [LAMP_W-1:0]  lamps_nxt;

  assign cfg_pready = 1'b1;
  assign cfg_index  = cfg_paddr[2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_comb begin
    unique case (cfg_index)
      REG_LONG_PRESS: cfg_prdata = DATA_W'(long_press_r);
      REG_PHASE_UNIT: cfg_prdata = DATA_W'(phase_unit_r);
      default:        cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      long_press_r <= LONG_PRESS_RESET;
      phase_unit_r <= PHASE_UNIT_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        REG_LONG_PRESS: long_press_r <= cfg_pwdata[PRESS_W-1:0];
        REG_PHASE_UNIT: phase_unit_r <= cfg_pwdata[UNIT_W-1:0];
        default: ;
      endcase
    end
  end

  // Advance the held beat whenever the result register is free or being drained
  assign advance  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) in_button_r <= in_button_level;
  end

  // Button is judged first; the lamp unit sees the updated wiper state
  wpms_press u_press (
    .clk              (clk),
    .rst_n            (rst_n),
    .advance          (advance),
    .button_level     (in_button_r),
    .long_press_ticks (long_press_r),
    .st_nxt           (st_nxt)
  );

  wpms_lamp u_lamp (
    .clk              (clk),
    .rst_n            (rst_n),
    .advance          (advance),
    .st               (st_nxt),
    .phase_unit_ticks (phase_unit_r),
    .lamps            (lamps_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Speed reads zero while the wiper is off
  always_ff @(posedge clk) begin
    if (advance) begin
      out_lamps_r <= lamps_nxt;
      out_wiper_r <= st_nxt.wiper_on;
      out_speed_r <= st_nxt.wiper_on ? st_nxt.speed : '0;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_lamps         = out_lamps_r;
  assign out_wiper_enabled = out_wiper_r;
  assign out_speed_level   = out_speed_r;

endmodule

/* rtl/wpms_checker.sv */
// Port-level checker for the wiper press-mode sequencer, bound to the top level.
// Depends on wpms_pkg and wiper_press_mode_sequencer_core.
module wpms_checker import wpms_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic [LAMP_W-1:0]  out_lamps,
  input logic               out_wiper_enabled,
  input logic [SPEED_W-1:0] out_speed_level
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat valid right after reset");

  a_off_dark: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_wiper_enabled) |-> (out_lamps == LAMP_OFF && out_speed_level == '0))
    else $error("lamps or speed active while wiper off");

  a_idle_red: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_wiper_enabled && out_speed_level == '0) |-> (out_lamps == LAMP_RED))
    else $error("idle wiper must show red only");

  a_pattern: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_wiper_enabled && out_speed_level != '0) |->
      (out_lamps == 4'h5 || out_lamps == 4'h6 || out_lamps == 4'hC))
    else $error("lamp pattern outside the four phases");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_lamps)))
    else $error("stalled result beat changed");

endmodule

bind wiper_press_mode_sequencer_core wpms_checker u_wpms_checker (.*);
